FILE: hdl/brpm_pkg.sv
`timescale 1ns / 1ps

package brpm_pkg;

  localparam int ACC_W    = 35;
  localparam int SUM_W    = 63;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int MAC_TAPS = 5;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  localparam logic [2:0] REG_B0        = 3'd0;
  localparam logic [2:0] REG_B1        = 3'd1;
  localparam logic [2:0] REG_B2        = 3'd2;
  localparam logic [2:0] REG_A1        = 3'd3;
  localparam logic [2:0] REG_A2        = 3'd4;
  localparam logic [2:0] REG_SHIFT     = 3'd5;
  localparam logic [2:0] REG_THRESHOLD = 3'd6;
  localparam logic [2:0] REG_MIDPOINT  = 3'd7;

  typedef struct packed {
    logic signed [15:0] b0;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] a1;
    logic signed [15:0] a2;
    logic [3:0]         post_shift;
    logic [14:0]        threshold;
    logic [11:0]        midpoint;
  } cfg_t;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] x;
    logic [31:0]        ts;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_SCALE,
    ST_SQUARE,
    ST_ACCUM,
    ST_REPORT
  } state_t;

endpackage

FILE: hdl/brpm_front.sv
`timescale 1ns / 1ps

module brpm_front import brpm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [11:0] in_adc_sample,
  input  logic [31:0] in_timestamp,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  localparam logic [QPTR_W:0] FULL = (QPTR_W + 1)'(QDEPTH);

  logic signed [12:0] diff;
  logic signed [16:0] scaled;
  logic signed [15:0] x_sat;
  item_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QPTR_W:0]    count_r;
  logic               push;

  // midpoint removal, x16, saturate to Q15
  assign diff   = $signed({1'b0, in_adc_sample}) - $signed({1'b0, cfg.midpoint});
  assign scaled = {diff, 4'b0000};

  always_comb begin
    if (scaled[16] != scaled[15]) begin
      x_sat = scaled[16] ? 16'h8000 : 16'h7fff;
    end else begin
      x_sat = scaled[15:0];
    end
  end

  assign in_ready = (count_r != FULL);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{cmd: in_cmd, x: x_sat, ts: in_timestamp};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count lost a push");

endmodule

FILE: hdl/brpm_back.sv
`timescale 1ns / 1ps

module brpm_back import brpm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_filtered,
  output logic [SUM_W-1:0]   out_sum_squares,
  output logic [31:0]        out_sample_count,
  output logic [31:0]        out_period_ticks,
  output logic               out_period_valid
);

  state_t                    state_r;
  state_t                    state_nxt;
  logic [2:0]                idx_r;
  logic signed [31:0]        prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [15:0]        y_r;
  logic signed [15:0]        x1_r;
  logic signed [15:0]        x2_r;
  logic signed [15:0]        y1_r;
  logic signed [15:0]        y2_r;
  logic [SUM_W-1:0]          sum_r;
  logic [31:0]               cnt_r;
  logic                      fired_r;
  logic [31:0]               last_cap_r;
  logic [31:0]               period_r;
  logic                      pnew_r;
  logic                      out_valid_r;

  logic signed [15:0]        mul_a;
  logic signed [15:0]        mul_b;
  logic signed [31:0]        mul_p;
  logic signed [ACC_W-1:0]   shifted;
  logic signed [15:0]        y_sat;
  logic [SUM_W:0]            sum_add;
  logic signed [16:0]        y_ext;
  logic signed [16:0]        thr_pos;
  logic signed [16:0]        thr_neg;
  logic                      fire;
  logic                      rearm;
  logic                      out_free;
  logic                      ld_sample;
  logic                      ld_report;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_item.cmd == CMD_REPORT) ? ST_REPORT : ST_MAC;
        end
      end
      ST_MAC: begin
        if (idx_r == 3'(MAC_TAPS)) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE:  state_nxt = ST_SQUARE;
      ST_SQUARE: state_nxt = ST_ACCUM;
      ST_ACCUM, ST_REPORT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // controls and shared multiplier operands
  always_comb begin
    out_free  = !out_valid_r || out_ready;
    ld_sample = (state_r == ST_ACCUM) && out_free;
    ld_report = (state_r == ST_REPORT) && out_free;
    q_pop     = ld_sample || ld_report;
    mul_a     = cfg.b0;
    mul_b     = q_item.x;
    if (state_r == ST_SQUARE) begin
      mul_a = y_r;
      mul_b = y_r;
    end else begin
      case (idx_r)
        3'd1: begin
          mul_a = cfg.b1;
          mul_b = x1_r;
        end
        3'd2: begin
          mul_a = cfg.b2;
          mul_b = x2_r;
        end
        3'd3: begin
          mul_a = cfg.a1;
          mul_b = y1_r;
        end
        3'd4: begin
          mul_a = cfg.a2;
          mul_b = y2_r;
        end
        default: begin
          mul_a = cfg.b0;
          mul_b = q_item.x;
        end
      endcase
    end
  end

  assign mul_p   = mul_a * mul_b;
  assign shifted = acc_r >>> (4'd15 - cfg.post_shift);

  always_comb begin
    if (!(&shifted[ACC_W-1:15] || ~|shifted[ACC_W-1:15])) begin
      y_sat = shifted[ACC_W-1] ? 16'h8000 : 16'h7fff;
    end else begin
      y_sat = shifted[15:0];
    end
  end

  assign sum_add = {1'b0, sum_r} + {{(SUM_W - 30){1'b0}}, prod_r[30:0]};
  assign y_ext   = {y_r[15], y_r};
  assign thr_pos = $signed({2'b00, cfg.threshold});
  assign thr_neg = -thr_pos;
  assign fire    = !fired_r && (y_ext > thr_pos);
  assign rearm   = fired_r && (y_ext < thr_neg);

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      acc_r <= '0;
    end
    if (state_r == ST_MAC) begin
      if (idx_r < 3'(MAC_TAPS)) begin
        prod_r <= mul_p;
      end
      if (idx_r != 3'd0) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
    if (state_r == ST_SCALE) begin
      y_r <= y_sat;
    end
    if (state_r == ST_SQUARE) begin
      prod_r <= mul_p;
    end
    if (ld_sample) begin
      out_filtered     <= y_r;
      out_sum_squares  <= '0;
      out_sample_count <= '0;
      out_period_ticks <= '0;
      out_period_valid <= 1'b0;
    end else if (ld_report) begin
      out_filtered     <= '0;
      out_sum_squares  <= sum_r;
      out_sample_count <= cnt_r;
      out_period_ticks <= period_r;
      out_period_valid <= pnew_r;
    end
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      x1_r        <= '0;
      x2_r        <= '0;
      y1_r        <= '0;
      y2_r        <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      fired_r     <= 1'b0;
      last_cap_r  <= '0;
      period_r    <= '0;
      pnew_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE) begin
        idx_r <= '0;
      end else if (state_r == ST_MAC && idx_r != 3'(MAC_TAPS)) begin
        idx_r <= idx_r + 1'b1;
      end
      if (ld_sample) begin
        x2_r  <= x1_r;
        x1_r  <= q_item.x;
        y2_r  <= y1_r;
        y1_r  <= y_r;
        sum_r <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
        if (cnt_r != '1) begin
          cnt_r <= cnt_r + 1'b1;
        end
        if (fire) begin
          if (last_cap_r != '0) begin
            period_r <= q_item.ts - last_cap_r;
            pnew_r   <= 1'b1;
          end
          last_cap_r <= q_item.ts;
          fired_r    <= 1'b1;
        end else if (rearm) begin
          fired_r <= 1'b0;
        end
      end
      if (ld_report) begin
        sum_r <= '0;
        cnt_r <= '0;
        if (cnt_r != '0) begin
          pnew_r <= 1'b0;
        end
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= 3'(MAC_TAPS))
    else $error("tap counter out of range");

  a_report_zero_y: assert property (@(posedge clk) disable iff (!rst_n)
    ld_report |=> (out_valid && out_filtered == '0))
    else $error("report carries nonzero filter output");

  a_sample_zero_stats: assert property (@(posedge clk) disable iff (!rst_n)
    ld_sample |=> (out_valid && out_sum_squares == '0 && !out_period_valid))
    else $error("sample result carries statistics");

endmodule

FILE: hdl/biquad_rms_period_meter.sv
`timescale 1ns / 1ps

// channel  ports                                               direction
// in       in_valid/in_ready, in_cmd, in_adc_sample, in_timestamp     in
// out      out_valid/out_ready, out_filtered, out_sum_squares,
//          out_sample_count, out_period_ticks, out_period_valid      out
// cfg      cfg_valid/cfg_ready, cfg_index, cfg_data                   in
//
// A sample passes from queue head to result through five taps on one
// 16x16 multiplier, then scale, square and update. A report skips these steps.
// A two-entry queue takes input transfers while the filter works; the output
// register holds one result, and the filter waits at its last step until it
// is free. cfg_ready is always high. rst_n is synchronous, active low, and
// restores coefficients and clears all statistics.

module biquad_rms_period_meter import brpm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [11:0]        in_adc_sample,
  input  logic [31:0]        in_timestamp,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_filtered,
  output logic [SUM_W-1:0]   out_sum_squares,
  output logic [31:0]        out_sample_count,
  output logic [31:0]        out_period_ticks,
  output logic               out_period_valid,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  cfg_t  cfg_r;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.b0         <= 16'sd8063;
      cfg_r.b1         <= 16'sd0;
      cfg_r.b2         <= -16'sd8063;
      cfg_r.a1         <= 16'sd16127;
      cfg_r.a2         <= -16'sd257;
      cfg_r.post_shift <= 4'd0;
      cfg_r.threshold  <= 15'd2500;
      cfg_r.midpoint   <= 12'd2048;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_B0:        cfg_r.b0         <= cfg_data;
        REG_B1:        cfg_r.b1         <= cfg_data;
        REG_B2:        cfg_r.b2         <= cfg_data;
        REG_A1:        cfg_r.a1         <= cfg_data;
        REG_A2:        cfg_r.a2         <= cfg_data;
        REG_SHIFT:     cfg_r.post_shift <= cfg_data[3:0];
        REG_THRESHOLD: cfg_r.threshold  <= cfg_data[14:0];
        REG_MIDPOINT:  cfg_r.midpoint   <= cfg_data[11:0];
        default:       cfg_r.b0         <= cfg_r.b0;
      endcase
    end
  end

  brpm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_adc_sample (in_adc_sample),
    .in_timestamp  (in_timestamp),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  brpm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_filtered     (out_filtered),
    .out_sum_squares  (out_sum_squares),
    .out_sample_count (out_sample_count),
    .out_period_ticks (out_period_ticks),
    .out_period_valid (out_period_valid)
  );

endmodule
